// ----- rtl/core/ttet_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed tag expiry table package
// Command and event codes and the fixed field widths of the block's ports.
// ----------------------------------------------------------------------------
package ttet_pkg;

	localparam int MODE_W     = 3;
	localparam int TAG_W      = 16;
	localparam int DUR_W      = 24;
	localparam int EVENT_W    = 4;
	localparam int REM_W      = 32;
	localparam int INTERVAL_W = 16;

	localparam logic [MODE_W-1:0] MODE_APPLY  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	localparam logic [EVENT_W-1:0] EV_ADDED     = 4'd0;
	localparam logic [EVENT_W-1:0] EV_UPDATED   = 4'd1;
	localparam logic [EVENT_W-1:0] EV_SKIPPED   = 4'd2;
	localparam logic [EVENT_W-1:0] EV_REJECTED  = 4'd3;
	localparam logic [EVENT_W-1:0] EV_FULL      = 4'd4;
	localparam logic [EVENT_W-1:0] EV_REMOVED   = 4'd5;
	localparam logic [EVENT_W-1:0] EV_ABSENT    = 4'd6;
	localparam logic [EVENT_W-1:0] EV_REMAINING = 4'd7;
	localparam logic [EVENT_W-1:0] EV_EXPIRED   = 4'd8;
	localparam logic [EVENT_W-1:0] EV_TICKDONE  = 4'd9;
	localparam logic [EVENT_W-1:0] EV_CLEARED   = 4'd10;
	localparam logic [EVENT_W-1:0] EV_CLEARDONE = 4'd11;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd50;

endpackage

// ----- rtl/core/ttet_cell.sv -----
// ----------------------------------------------------------------------------
// Timed tag expiry table cell
// One table entry of the ring; it loads its neighbor's entry when the ring shifts.
// ----------------------------------------------------------------------------
module ttet_cell #(
	parameter int KW = 16,
	parameter int TW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          in_valid,
	input  logic [KW-1:0] in_key,
	input  logic [TW-1:0] in_end_time,
	output logic          valid,
	output logic [KW-1:0] key,
	output logic [TW-1:0] end_time
);

	logic          valid_q;
	logic [KW-1:0] key_q;
	logic [TW-1:0] end_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q      <= in_key;
			end_time_q <= in_end_time;
		end
	end

	assign valid    = valid_q;
	assign key      = key_q;
	assign end_time = end_time_q;

endmodule

// ----- rtl/core/timed_tag_expiry_table_core.sv -----
// ----------------------------------------------------------------------------
// Timed tag expiry table core
// Keyed table of timed tags held in a rotating ring of entry cells.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The entries sit in a
// ring of TABLE_ENTRIES cells that turns one place per cycle past a single head
// cell, where the controller inspects and edits each entry in ascending slot
// order. Remove, query, update of a present tag, a tick that sweeps and clear
// each take one full turn and then the final result. Adding a new tag needs a
// second turn to write the first free slot. A rejected command, a remove or
// query of tag 0 and a tick without a sweep finish in the cycle they are taken
// and keep busy low. Results come out at most one per cycle, each on
// result_strobe for exactly one cycle; the receiver cannot hold them off and
// must take every transfer.
// ----------------------------------------------------------------------------
module timed_tag_expiry_table_core #(
	parameter int TABLE_ENTRIES = 16,
	parameter int KEY_BITS      = 16,
	parameter int TIME_BITS     = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ttet_pkg::MODE_W-1:0]     mode,
	input  logic [ttet_pkg::TAG_W-1:0]      tag_id,
	input  logic [ttet_pkg::DUR_W-1:0]      duration,
	input  logic                            stack_flag,
	input  logic                            cfg_wr_en,
	input  logic [ttet_pkg::INTERVAL_W-1:0] cfg_wr_data,
	output logic                            result_strobe,
	output logic [ttet_pkg::EVENT_W-1:0]    event_res,
	output logic [ttet_pkg::TAG_W-1:0]      tag_key,
	output logic [ttet_pkg::REM_W-1:0]      remaining_ticks,
	output logic                            last_of_run
);

	localparam int N  = TABLE_ENTRIES;
	localparam int KW = (KEY_BITS < ttet_pkg::TAG_W) ? KEY_BITS : ttet_pkg::TAG_W;
	localparam int TW = TIME_BITS;
	localparam int IW = $clog2(N);
	localparam int SW = ((TW > ttet_pkg::DUR_W) ? TW : ttet_pkg::DUR_W) + 1;
	localparam int RW = (TW > ttet_pkg::REM_W) ? TW : ttet_pkg::REM_W;
	localparam logic [SW-1:0] TMAX     = SW'({TW{1'b1}});
	localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
		input logic [ttet_pkg::DUR_W-1:0] b);
		logic [SW-1:0] sum;
		sum = SW'(a) + SW'(b);
		return (sum > TMAX) ? {TW{1'b1}} : sum[TW-1:0];
	endfunction

	function automatic logic [ttet_pkg::REM_W-1:0] sat_rem(input logic [TW-1:0] d);
		logic [RW-1:0] w;
		w = RW'(d);
		return (w > RW'({ttet_pkg::REM_W{1'b1}})) ? {ttet_pkg::REM_W{1'b1}}
			: w[ttet_pkg::REM_W-1:0];
	endfunction

	logic [1:0]                      state_q;
	logic [IW-1:0]                   cnt_q;
	logic [ttet_pkg::MODE_W-1:0]     mode_q;
	logic [KW-1:0]                   key_q;
	logic [ttet_pkg::DUR_W-1:0]      dur_q;
	logic                            stack_q;
	logic [TW-1:0]                   addc_q;
	logic                            found_q;
	logic                            free_found_q;
	logic [IW-1:0]                   free_idx_q;
	logic                            any_q;
	logic [ttet_pkg::EVENT_W-1:0]    ev_q;
	logic [ttet_pkg::REM_W-1:0]      rem_q;
	logic [TW-1:0]                   cur_time_q;
	logic [ttet_pkg::INTERVAL_W-1:0] sweep_countdown_q;
	logic                            sweep_running_q;
	logic [ttet_pkg::INTERVAL_W-1:0] sweep_interval_q;

	logic                            result_strobe_q;
	logic [ttet_pkg::EVENT_W-1:0]    event_res_q;
	logic [ttet_pkg::TAG_W-1:0]      tag_key_q;
	logic [ttet_pkg::REM_W-1:0]      remaining_ticks_q;
	logic                            last_of_run_q;

	logic          cell_valid [N];
	logic [KW-1:0] cell_key   [N];
	logic [TW-1:0] cell_end   [N];
	logic          head_valid;
	logic [KW-1:0] head_key;
	logic [TW-1:0] head_end;
	logic          tail_valid;
	logic [KW-1:0] tail_key;
	logic [TW-1:0] tail_end;
	logic          shift;

	logic          accept;
	logic [KW-1:0] in_key;
	logic          hit;
	logic          expired;
	logic          upd_ok;
	logic [TW-1:0] nend;
	logic          tick_sweep;
	logic [ttet_pkg::INTERVAL_W-1:0] interval_val;

	logic                         em_en;
	logic [ttet_pkg::EVENT_W-1:0] em_ev;
	logic [ttet_pkg::TAG_W-1:0]   em_key;
	logic [ttet_pkg::REM_W-1:0]   em_rem;
	logic                         em_last;

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			logic          nb_valid;
			logic [KW-1:0] nb_key;
			logic [TW-1:0] nb_end;
			if (gi == N - 1) begin : g_tail
				assign nb_valid = tail_valid;
				assign nb_key   = tail_key;
				assign nb_end   = tail_end;
			end else begin : g_mid
				assign nb_valid = cell_valid[gi+1];
				assign nb_key   = cell_key[gi+1];
				assign nb_end   = cell_end[gi+1];
			end
			ttet_cell #(
				.KW(KW),
				.TW(TW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift      (shift),
				.in_valid   (nb_valid),
				.in_key     (nb_key),
				.in_end_time(nb_end),
				.valid      (cell_valid[gi]),
				.key        (cell_key[gi]),
				.end_time   (cell_end[gi])
			);
		end
	endgenerate

	assign head_valid = cell_valid[0];
	assign head_key   = cell_key[0];
	assign head_end   = cell_end[0];

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign shift        = (state_q == ST_SCAN) || (state_q == ST_WRITE);
	assign in_key       = tag_id[KW-1:0];
	assign interval_val = (sweep_interval_q == '0) ? 16'd1 : sweep_interval_q;
	assign tick_sweep   = sweep_running_q && (sweep_countdown_q <= 16'd1);

	assign hit     = head_valid && (head_key == key_q);
	assign expired = head_valid && (cur_time_q >= head_end);
	assign nend    = (stack_q && (head_end > cur_time_q)) ? sat_add(head_end, dur_q) : addc_q;
	assign upd_ok  = stack_q || (addc_q > head_end);

	always_comb begin
		tail_valid = head_valid;
		tail_key   = head_key;
		tail_end   = head_end;
		if (state_q == ST_SCAN) begin
			case (mode_q)
				ttet_pkg::MODE_APPLY: begin
					if (hit && upd_ok) begin
						tail_end = nend;
					end
				end
				ttet_pkg::MODE_REMOVE: begin
					if (hit) begin
						tail_valid = 1'b0;
					end
				end
				ttet_pkg::MODE_TICK: begin
					if (expired) begin
						tail_valid = 1'b0;
					end
				end
				ttet_pkg::MODE_CLEAR: begin
					tail_valid = 1'b0;
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_WRITE && cnt_q == free_idx_q) begin
			tail_valid = 1'b1;
			tail_key   = key_q;
			tail_end   = addc_q;
		end
	end

	always_comb begin
		em_en   = 1'b0;
		em_ev   = ttet_pkg::EV_REJECTED;
		em_key  = ttet_pkg::TAG_W'(key_q);
		em_rem  = '0;
		em_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				em_key = ttet_pkg::TAG_W'(in_key);
				if (accept) begin
					case (mode)
						ttet_pkg::MODE_APPLY: begin
							em_en = (in_key == '0) || (duration == '0);
						end
						ttet_pkg::MODE_REMOVE, ttet_pkg::MODE_QUERY: begin
							em_en = (in_key == '0);
							em_ev = ttet_pkg::EV_ABSENT;
						end
						ttet_pkg::MODE_TICK: begin
							em_en  = !tick_sweep;
							em_ev  = ttet_pkg::EV_TICKDONE;
							em_key = '0;
						end
						ttet_pkg::MODE_CLEAR: begin
							em_en = 1'b0;
						end
						default: begin
							em_en = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				em_key  = ttet_pkg::TAG_W'(head_key);
				em_last = 1'b0;
				if (mode_q == ttet_pkg::MODE_TICK) begin
					em_en = expired;
					em_ev = ttet_pkg::EV_EXPIRED;
				end else if (mode_q == ttet_pkg::MODE_CLEAR) begin
					em_en = head_valid;
					em_ev = ttet_pkg::EV_CLEARED;
				end
			end
			ST_FIN: begin
				em_en = 1'b1;
				case (mode_q)
					ttet_pkg::MODE_APPLY: begin
						em_ev = found_q ? ev_q : ttet_pkg::EV_FULL;
					end
					ttet_pkg::MODE_REMOVE: begin
						em_ev = found_q ? ttet_pkg::EV_REMOVED : ttet_pkg::EV_ABSENT;
					end
					ttet_pkg::MODE_QUERY: begin
						em_ev  = found_q ? ttet_pkg::EV_REMAINING : ttet_pkg::EV_ABSENT;
						em_rem = found_q ? rem_q : '0;
					end
					ttet_pkg::MODE_TICK: begin
						em_ev  = ttet_pkg::EV_TICKDONE;
						em_key = '0;
					end
					ttet_pkg::MODE_CLEAR: begin
						em_ev  = ttet_pkg::EV_CLEARDONE;
						em_key = '0;
					end
					default: begin
						em_ev = ttet_pkg::EV_REJECTED;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= em_en;
		end
	end

	always_ff @(posedge clk) begin
		if (em_en) begin
			event_res_q       <= em_ev;
			tag_key_q         <= em_key;
			remaining_ticks_q <= em_rem;
			last_of_run_q     <= em_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_interval_q <= ttet_pkg::INTERVAL_RESET;
		end else if (cfg_wr_en) begin
			sweep_interval_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			cnt_q             <= '0;
			found_q           <= 1'b0;
			free_found_q      <= 1'b0;
			any_q             <= 1'b0;
			cur_time_q        <= '0;
			sweep_countdown_q <= '0;
			sweep_running_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q        <= '0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					any_q        <= 1'b0;
					if (accept) begin
						case (mode)
							ttet_pkg::MODE_APPLY: begin
								if (in_key != '0 && duration != '0) begin
									state_q <= ST_SCAN;
								end
							end
							ttet_pkg::MODE_REMOVE, ttet_pkg::MODE_QUERY: begin
								if (in_key != '0) begin
									state_q <= ST_SCAN;
								end
							end
							ttet_pkg::MODE_TICK: begin
								cur_time_q <= sat_add(cur_time_q, ttet_pkg::DUR_W'(1));
								if (tick_sweep) begin
									sweep_countdown_q <= interval_val;
									state_q           <= ST_SCAN;
								end else if (sweep_running_q) begin
									sweep_countdown_q <= sweep_countdown_q - 16'd1;
								end
							end
							ttet_pkg::MODE_CLEAR: begin
								sweep_running_q   <= 1'b0;
								sweep_countdown_q <= '0;
								state_q           <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					case (mode_q)
						ttet_pkg::MODE_APPLY: begin
							if (hit) begin
								found_q <= 1'b1;
							end
							if (!head_valid && !free_found_q) begin
								free_found_q <= 1'b1;
							end
						end
						ttet_pkg::MODE_REMOVE, ttet_pkg::MODE_QUERY: begin
							if (hit) begin
								found_q <= 1'b1;
							end
						end
						ttet_pkg::MODE_TICK: begin
							if (head_valid && !expired) begin
								any_q <= 1'b1;
							end
						end
						default: begin
						end
					endcase
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						if (mode_q == ttet_pkg::MODE_APPLY && !found_q && !hit
							&& (free_found_q || !head_valid)) begin
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_WRITE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						found_q <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					if (mode_q == ttet_pkg::MODE_APPLY && found_q
						&& ev_q != ttet_pkg::EV_SKIPPED && !sweep_running_q) begin
						sweep_running_q   <= 1'b1;
						sweep_countdown_q <= interval_val;
					end
					if (mode_q == ttet_pkg::MODE_TICK && !any_q) begin
						sweep_running_q   <= 1'b0;
						sweep_countdown_q <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			key_q   <= in_key;
			dur_q   <= duration;
			stack_q <= stack_flag;
			addc_q  <= sat_add(cur_time_q, duration);
		end
		if (state_q == ST_SCAN) begin
			if (mode_q == ttet_pkg::MODE_APPLY && hit) begin
				ev_q <= upd_ok ? ttet_pkg::EV_UPDATED : ttet_pkg::EV_SKIPPED;
			end
			if (mode_q == ttet_pkg::MODE_APPLY && !head_valid && !free_found_q) begin
				free_idx_q <= cnt_q;
			end
			if (mode_q == ttet_pkg::MODE_QUERY && hit) begin
				rem_q <= (head_end > cur_time_q) ? sat_rem(head_end - cur_time_q) : '0;
			end
		end
		if (state_q == ST_WRITE) begin
			ev_q <= ttet_pkg::EV_ADDED;
		end
	end

	assign result_strobe   = result_strobe_q;
	assign event_res       = event_res_q;
	assign tag_key         = tag_key_q;
	assign remaining_ticks = remaining_ticks_q;
	assign last_of_run     = last_of_run_q;

	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_of_run |-> busy)
		else $error("non-final result outside a running command");

	a_done_final: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_strobe && last_of_run)
		else $error("command ended without a final result");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == ttet_pkg::MODE_TICK && !sweep_running_q
		|=> result_strobe && event_res == ttet_pkg::EV_TICKDONE && !busy)
		else $error("tick without sweep did not finish at once");

	a_countdown_run: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_running_q == (sweep_countdown_q != '0))
		else $error("sweep countdown out of step with sweep state");

endmodule

// ----- test/timed_tag_expiry_table_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed tag expiry table core testbench
// Sends apply, remove, query, tick and clear commands, some directed and some
// random, across several sweep intervals. Every result transfer is checked
// field by field against a behavioral copy of the table kept in this file.
// ----------------------------------------------------------------------------
module timed_tag_expiry_table_core_tb;

	localparam int SLOTS = 16;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 6;
	localparam realtime RUN_LIMIT = 2ms;
	localparam logic [ttet_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [ttet_pkg::MODE_W-1:0] MODE_UNUSED_LAST = 3'd7;

	typedef struct packed {
		logic [ttet_pkg::EVENT_W-1:0] ev;
		logic [ttet_pkg::TAG_W-1:0] key;
		logic [ttet_pkg::REM_W-1:0] rem;
		logic last;
	} tag_event_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [ttet_pkg::MODE_W-1:0] mode;
	logic [ttet_pkg::TAG_W-1:0] tag_id;
	logic [ttet_pkg::DUR_W-1:0] duration;
	logic stack_flag;
	logic cfg_wr_en;
	logic [ttet_pkg::INTERVAL_W-1:0] cfg_wr_data;
	logic result_strobe;
	logic [ttet_pkg::EVENT_W-1:0] event_res;
	logic [ttet_pkg::TAG_W-1:0] tag_key;
	logic [ttet_pkg::REM_W-1:0] remaining_ticks;
	logic last_of_run;

	// Shadow copy of the table, updated on every accepted command.
	bit tbl_valid [SLOTS];
	logic [ttet_pkg::TAG_W-1:0] tbl_key [SLOTS];
	logic [ttet_pkg::REM_W-1:0] tbl_end [SLOTS];
	logic [ttet_pkg::REM_W-1:0] now_ticks = '0;
	logic [ttet_pkg::INTERVAL_W-1:0] sweep_count = '0;
	bit sweep_on = 1'b0;
	logic [ttet_pkg::INTERVAL_W-1:0] interval_reg = ttet_pkg::INTERVAL_RESET;

	tag_event_t pending_events [$];
	int error_count = 0;
	int commands_taken = 0;
	int results_checked = 0;
	int expiries_seen = 0;
	int fulls_seen = 0;

	timed_tag_expiry_table_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.tag_id         (tag_id),
		.duration       (duration),
		.stack_flag     (stack_flag),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.result_strobe  (result_strobe),
		.event_res      (event_res),
		.tag_key        (tag_key),
		.remaining_ticks(remaining_ticks),
		.last_of_run    (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("timed_tag_expiry_table_core test failed");
		$finish;
	end

	function automatic logic [ttet_pkg::REM_W-1:0] time_sum(
			logic [ttet_pkg::REM_W-1:0] a, logic [ttet_pkg::REM_W-1:0] b);
		logic [ttet_pkg::REM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ttet_pkg::REM_W] ? '1 : s[ttet_pkg::REM_W-1:0];
	endfunction

	function automatic logic [ttet_pkg::INTERVAL_W-1:0] sweep_reload();
		return (interval_reg == '0) ? ttet_pkg::INTERVAL_W'(1) : interval_reg;
	endfunction

	function automatic int slot_of(logic [ttet_pkg::TAG_W-1:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic void push_event(logic [ttet_pkg::EVENT_W-1:0] ev,
			logic [ttet_pkg::TAG_W-1:0] key, logic [ttet_pkg::REM_W-1:0] rem, logic last);
		pending_events.push_back('{ev: ev, key: key, rem: rem, last: last});
	endfunction

	function automatic void apply_tag(logic [ttet_pkg::TAG_W-1:0] key,
			logic [ttet_pkg::DUR_W-1:0] dur, logic stk);
		int slot;
		logic [ttet_pkg::REM_W-1:0] span;
		logic [ttet_pkg::REM_W-1:0] new_end;
		logic [ttet_pkg::EVENT_W-1:0] ev;
		span = ttet_pkg::REM_W'(dur);
		if (key == '0 || dur == '0) begin
			push_event(ttet_pkg::EV_REJECTED, key, '0, 1'b1);
			return;
		end
		slot = slot_of(key);
		if (slot >= 0) begin
			if (stk) begin
				new_end = time_sum((tbl_end[slot] > now_ticks) ? tbl_end[slot] : now_ticks, span);
			end else begin
				new_end = time_sum(now_ticks, span);
				if (new_end <= tbl_end[slot]) begin
					push_event(ttet_pkg::EV_SKIPPED, key, '0, 1'b1);
					return;
				end
			end
			tbl_end[slot] = new_end;
			ev = ttet_pkg::EV_UPDATED;
		end else begin
			for (int i = 0; i < SLOTS && slot < 0; i++)
				if (!tbl_valid[i])
					slot = i;
			if (slot < 0) begin
				push_event(ttet_pkg::EV_FULL, key, '0, 1'b1);
				return;
			end
			tbl_valid[slot] = 1'b1;
			tbl_key[slot] = key;
			tbl_end[slot] = time_sum(now_ticks, span);
			ev = ttet_pkg::EV_ADDED;
		end
		if (!sweep_on) begin
			sweep_on = 1'b1;
			sweep_count = sweep_reload();
		end
		push_event(ev, key, '0, 1'b1);
	endfunction

	function automatic void predict_command(logic [ttet_pkg::MODE_W-1:0] m,
			logic [ttet_pkg::TAG_W-1:0] key, logic [ttet_pkg::DUR_W-1:0] dur, logic stk);
		int slot;
		bit any_left;
		slot = (key != '0) ? slot_of(key) : -1;
		case (m)
			ttet_pkg::MODE_APPLY: apply_tag(key, dur, stk);
			ttet_pkg::MODE_REMOVE: begin
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b0;
					push_event(ttet_pkg::EV_REMOVED, key, '0, 1'b1);
				end else begin
					push_event(ttet_pkg::EV_ABSENT, key, '0, 1'b1);
				end
			end
			ttet_pkg::MODE_QUERY: begin
				if (slot >= 0)
					push_event(ttet_pkg::EV_REMAINING, key,
						(tbl_end[slot] > now_ticks) ? tbl_end[slot] - now_ticks : '0, 1'b1);
				else
					push_event(ttet_pkg::EV_ABSENT, key, '0, 1'b1);
			end
			ttet_pkg::MODE_TICK: begin
				now_ticks = time_sum(now_ticks, ttet_pkg::REM_W'(1));
				if (sweep_on) begin
					if (sweep_count <= 1) begin
						any_left = 1'b0;
						for (int i = 0; i < SLOTS; i++) begin
							if (tbl_valid[i] && now_ticks >= tbl_end[i]) begin
								tbl_valid[i] = 1'b0;
								push_event(ttet_pkg::EV_EXPIRED, tbl_key[i], '0, 1'b0);
							end
							any_left |= tbl_valid[i];
						end
						sweep_count = sweep_reload();
						if (!any_left) begin
							sweep_on = 1'b0;
							sweep_count = '0;
						end
					end else begin
						sweep_count--;
					end
				end
				push_event(ttet_pkg::EV_TICKDONE, '0, '0, 1'b1);
			end
			ttet_pkg::MODE_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_valid[i]) begin
						tbl_valid[i] = 1'b0;
						push_event(ttet_pkg::EV_CLEARED, tbl_key[i], '0, 1'b0);
					end
				end
				sweep_on = 1'b0;
				sweep_count = '0;
				push_event(ttet_pkg::EV_CLEARDONE, '0, '0, 1'b1);
			end
			default: push_event(ttet_pkg::EV_REJECTED, key, '0, 1'b1);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH %s", $realtime, what);
		error_count++;
	endtask

	// Tracks accepted commands and configuration writes, and checks every result transfer.
	always @(posedge clk) begin
		tag_event_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				interval_reg = cfg_wr_data;
			if (start && !busy) begin
				predict_command(mode, tag_id, duration, stack_flag);
				commands_taken++;
			end
			if (result_strobe) begin
				if (pending_events.size() == 0) begin
					report_mismatch($sformatf("unexpected result: event %0d tag %h",
						event_res, tag_key));
				end else begin
					want = pending_events.pop_front();
					results_checked++;
					if (event_res !== want.ev)
						report_mismatch($sformatf("event_res %0d, want %0d (tag %h)",
							event_res, want.ev, want.key));
					if (tag_key !== want.key)
						report_mismatch($sformatf("tag_key %h, want %h", tag_key, want.key));
					if (remaining_ticks !== want.rem)
						report_mismatch($sformatf("remaining_ticks %h, want %h (tag %h)",
							remaining_ticks, want.rem, want.key));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run %b, want %b (tag %h)",
							last_of_run, want.last, want.key));
					if (want.ev == ttet_pkg::EV_EXPIRED)
						expiries_seen++;
					if (want.ev == ttet_pkg::EV_FULL)
						fulls_seen++;
				end
			end
		end
	end

	task automatic send_command(input logic [ttet_pkg::MODE_W-1:0] m,
			input logic [ttet_pkg::TAG_W-1:0] key, input logic [ttet_pkg::DUR_W-1:0] dur,
			input logic stk);
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		tag_id <= key;
		duration <= dur;
		stack_flag <= stk;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	task automatic idle_burst(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_events.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_sweep_interval(input logic [ttet_pkg::INTERVAL_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_command(input int key_pool, input int tick_pct, input int clear_pct,
			input int short_max, input bit idle_on);
		int r;
		logic [ttet_pkg::MODE_W-1:0] m;
		logic [ttet_pkg::TAG_W-1:0] key;
		logic [ttet_pkg::DUR_W-1:0] dur;
		r = $urandom_range(0, 99);
		if (r < tick_pct) begin
			m = ttet_pkg::MODE_TICK;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3)
				m = ttet_pkg::MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
			else if (r < 3 + clear_pct)
				m = ttet_pkg::MODE_CLEAR;
			else if (r < 60)
				m = ttet_pkg::MODE_APPLY;
			else if (r < 72)
				m = ttet_pkg::MODE_REMOVE;
			else
				m = ttet_pkg::MODE_QUERY;
		end
		r = $urandom_range(0, 99);
		if (r < 4)
			key = '0;
		else if (r < 8)
			key = ttet_pkg::TAG_W'($urandom_range(0, 16'hFFFF));
		else
			key = ttet_pkg::TAG_W'($urandom_range(1, key_pool));
		r = $urandom_range(0, 99);
		if (r < 5)
			dur = '0;
		else if (r < 80)
			dur = ttet_pkg::DUR_W'($urandom_range(1, short_max));
		else
			dur = ttet_pkg::DUR_W'($urandom_range(1, 24'hFFFFFF));
		if (idle_on && $urandom_range(0, 3) == 0)
			idle_burst($urandom_range(1, 16));
		send_command(m, key, dur, 1'($urandom_range(0, 1)));
	endtask

	task automatic test_directed_ops();
		send_command(ttet_pkg::MODE_APPLY, 16'h0000, 24'd5, 1'b0);
		send_command(ttet_pkg::MODE_APPLY, 16'h0007, 24'd0, 1'b1);
		send_command(ttet_pkg::MODE_APPLY, 16'hFFFF, 24'hFFFFFF, 1'b0);
		send_command(ttet_pkg::MODE_QUERY, 16'hFFFF, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_APPLY, 16'hFFFF, 24'd1, 1'b0);
		send_command(ttet_pkg::MODE_APPLY, 16'hFFFF, 24'd10, 1'b1);
		send_command(ttet_pkg::MODE_APPLY, 16'h0001, 24'd2, 1'b1);
		send_command(ttet_pkg::MODE_APPLY, 16'h0001, 24'd5, 1'b0);
		send_command(ttet_pkg::MODE_QUERY, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_QUERY, 16'h0002, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_REMOVE, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_REMOVE, 16'h0003, 24'd0, 1'b0);
		for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
			send_command(ttet_pkg::MODE_W'(m), 16'hA5A5, 24'h5A5A5A, 1'b1);
		send_command(ttet_pkg::MODE_REMOVE, 16'h0001, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_TICK, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_APPLY, 16'h0002, 24'd1, 1'b0);
		send_command(ttet_pkg::MODE_QUERY, 16'hFFFF, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_CLEAR, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_CLEAR, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_TICK, 16'h0000, 24'd0, 1'b0);
	endtask

	// Tick-heavy traffic at the reset interval.
	task automatic test_reset_interval();
		for (int i = 0; i < 20; i++)
			random_command(6, 70, 1, 120, 1'b1);
	endtask

	task automatic test_sweep_expiry();
		send_command(ttet_pkg::MODE_CLEAR, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_APPLY, 16'h0005, 24'd1, 1'b0);
		send_command(ttet_pkg::MODE_APPLY, 16'h0006, 24'd3, 1'b0);
		send_command(ttet_pkg::MODE_TICK, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_TICK, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_TICK, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_TICK, 16'h0000, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_APPLY, 16'h0008, 24'd9, 1'b1);
		send_command(ttet_pkg::MODE_REMOVE, 16'h0008, 24'd0, 1'b0);
		send_command(ttet_pkg::MODE_TICK, 16'h0000, 24'd0, 1'b0);
		for (int k = 10; k < 13; k++)
			send_command(ttet_pkg::MODE_APPLY, ttet_pkg::TAG_W'(k), 24'd1, 1'b0);
		send_command(ttet_pkg::MODE_TICK, 16'h0000, 24'd0, 1'b0);
	endtask

	// New tags are added until the table is full; the sender drains once midway.
	task automatic test_full_table();
		for (int k = 1; k <= SLOTS + 1; k++) begin
			if (k == SLOTS / 2 + 1)
				wait_drained();
			send_command(ttet_pkg::MODE_APPLY, ttet_pkg::TAG_W'(16'h0100 + k), 24'd100, 1'b0);
		end
	endtask

	task automatic test_long_interval();
		for (int i = 0; i < 12; i++)
			random_command(8, 40, 5, 16, 1'b1);
	endtask

	// Large durations are stacked onto one tag, then a shorter extend is skipped.
	task automatic test_stacking();
		send_command(ttet_pkg::MODE_CLEAR, 16'h0000, 24'd0, 1'b0);
		for (int i = 0; i < 3; i++)
			send_command(ttet_pkg::MODE_APPLY, 16'h1234,
				ttet_pkg::DUR_W'($urandom_range(24'h800000, 24'hFFFFFF)), 1'b1);
		send_command(ttet_pkg::MODE_APPLY, 16'h1234, 24'hFFFFFF, 1'b0);
		send_command(ttet_pkg::MODE_QUERY, 16'h1234, 24'd0, 1'b0);
	endtask

	task automatic test_back_to_back();
		for (int i = 0; i < 20; i++)
			random_command(10, 35, 3, 20, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = ttet_pkg::MODE_APPLY;
		tag_id = '0;
		duration = '0;
		stack_flag = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_ops();
		test_reset_interval();
		set_sweep_interval(16'd1);
		test_sweep_expiry();
		set_sweep_interval(16'd0);
		test_full_table();
		set_sweep_interval(16'hFFFF);
		test_long_interval();
		set_sweep_interval(ttet_pkg::INTERVAL_RESET);
		test_stacking();
		set_sweep_interval(ttet_pkg::INTERVAL_W'($urandom_range(2, 6)));
		test_back_to_back();
		wait_drained();

		$display("Covered %0d commands and %0d result transfers: %0d expiries, %0d table-full",
			commands_taken, results_checked, expiries_seen, fulls_seen);
		$display("Sweep intervals 50, 1, 0, 65535 and a random one; a full table and stacking.");
		if (error_count == 0)
			$display("timed_tag_expiry_table_core test passed");
		else
			$display("timed_tag_expiry_table_core test failed");
		$finish;
	end

endmodule
